// ===== hw/rtl/lru_key_value_cache_macros.svh =====
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Concurrent assertion helpers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

`ifndef SYNTHESIS

`define LKV_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("lkv assertion failed");

`define LKV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lkv assertion failed");

`else

`define LKV_ASSERT(label, expr)

`define LKV_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/lkv_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared payload types, command codes and constants.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int KEY_W   = 31;
  localparam int VALUE_W = 32;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0]          CAP_RESET  = 5'd16;
  localparam logic signed [VALUE_W-1:0] MISS_VALUE = -32'sd1;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } lkv_cmd_t;

  typedef struct packed {
    lkv_cmd_t                   command;
    logic [KEY_W-1:0]           key;
    logic signed [VALUE_W-1:0]  value;
  } lkv_in_t;

  typedef struct packed {
    logic                       hit;
    logic signed [VALUE_W-1:0]  read_value;
  } lkv_out_t;

  typedef struct packed {
    logic                       hit;
    logic signed [VALUE_W-1:0]  value;
  } lkv_lookup_t;

endpackage

// ===== hw/rtl/lkv_table.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache entry table
// Fully associative key store with recency ranks; each registered request is
// looked up combinationally and the table is updated at the clock edge.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_macros.svh"

module lkv_table import lkv_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  lkv_in_t           req,
  input  logic [CAP_W-1:0]  capacity,
  output lkv_lookup_t       lookup
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [MAX_ENTRIES-1:0] valid;
  logic [KEY_W-1:0]       keys   [MAX_ENTRIES];
  logic [VALUE_W-1:0]     values [MAX_ENTRIES];
  logic [IDX_W-1:0]       ages   [MAX_ENTRIES];
  logic [CNT_W-1:0]       count;

  logic [MAX_ENTRIES-1:0] match;
  logic [MAX_ENTRIES-1:0] lru;
  logic                   hit;
  logic [IDX_W-1:0]       hit_idx;
  logic [IDX_W-1:0]       hit_age;
  logic [VALUE_W-1:0]     hit_value;
  logic [IDX_W-1:0]       lru_idx;
  logic [CMP_W-1:0]       cap_ext;
  logic [CMP_W-1:0]       eff_cap;
  logic                   full;
  logic                   is_put;

  logic                   touch;
  logic                   bump_all;
  logic                   write_entry;
  logic                   fill;
  logic [IDX_W-1:0]       tgt;

  always_comb begin
    match     = '0;
    lru       = '0;
    hit_idx   = '0;
    hit_age   = '0;
    hit_value = '0;
    lru_idx   = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i] = valid[i] && (keys[i] == req.key);
      lru[i]   = valid[i] && (CNT_W'(ages[i]) == count - CNT_W'(1));
      if (match[i]) begin
        hit_idx   = hit_idx | IDX_W'(i);
        hit_age   = hit_age | ages[i];
        hit_value = hit_value | values[i];
      end
      if (lru[i]) begin
        lru_idx = lru_idx | IDX_W'(i);
      end
    end
    hit = |match;
  end

  always_comb begin
    cap_ext = CMP_W'(capacity);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CMP_W'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    full   = CMP_W'(count) >= eff_cap;
    is_put = req.command == CMD_PUT;
  end

  always_comb begin
    touch       = 1'b0;
    bump_all    = 1'b0;
    write_entry = 1'b0;
    fill        = 1'b0;
    tgt         = hit_idx;
    if (req_valid) begin
      if (hit) begin
        touch       = 1'b1;
        write_entry = is_put;
      end else if (is_put) begin
        touch       = 1'b1;
        bump_all    = 1'b1;
        write_entry = 1'b1;
        if (full) begin
          tgt = lru_idx;
        end else begin
          tgt  = count[IDX_W-1:0];
          fill = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        ages[i] <= '0;
      end
    end else if (touch) begin
      if (fill) begin
        valid[tgt] <= 1'b1;
        count      <= count + CNT_W'(1);
      end
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (IDX_W'(i) == tgt) begin
          ages[i] <= '0;
        end else if (valid[i] && (bump_all || ages[i] < hit_age)) begin
          ages[i] <= ages[i] + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (write_entry) begin
      keys[tgt]   <= req.key;
      values[tgt] <= req.value;
    end
  end

  assign lookup.hit   = hit;
  assign lookup.value = hit_value;

  `LKV_ASSERT(a_keys_unique, $onehot0(match))
  `LKV_ASSERT(a_count_tracks_valid, $countones(valid) == count)
  `LKV_ASSERT_NEXT(a_get_keeps_count, req_valid && req.command == CMD_GET, $stable(count))

endmodule

// ===== hw/rtl/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// A request is taken whenever start is high and busy is low; busy is high
// only during reset, so one request can be issued every clock cycle. The
// result of a get passes the req and result registers and shows with done
// high for exactly one cycle; the receiver must take it then. A put gives no
// result. The entry table, which compares all keys and updates all recency
// ranks together, sets the rate of one request per cycle. Valid marks clear
// directly at reset, with no clearing pass. The user must write the capacity
// register on the cfg channel while no request is in flight; not enforced.
`include "lru_key_value_cache_macros.svh"

module lru_key_value_cache import lkv_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  lkv_in_t           request,
  output logic              done,
  output lkv_out_t          result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CAP_W-1:0]  cfg_data
);

  logic              req_valid;
  lkv_in_t           req;
  logic [CAP_W-1:0]  capacity;
  lkv_lookup_t       lookup;

  assign busy      = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req <= request;
    end
  end

  lkv_table #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .capacity  (capacity),
    .lookup    (lookup)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid && (req.command == CMD_GET);
    end
  end

  always_ff @(posedge clk) begin
    result.hit        <= lookup.hit;
    result.read_value <= lookup.hit ? lookup.value : MISS_VALUE;
  end

  `LKV_ASSERT_NEXT(a_get_gives_result, req_valid && req.command == CMD_GET, done)
  `LKV_ASSERT_NEXT(a_put_gives_none, req_valid && req.command == CMD_PUT, !done)
  `LKV_ASSERT(a_miss_value, !done || result.hit || result.read_value == MISS_VALUE)

endmodule

// ===== bench/tb_lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives a directed table of gets, puts and capacity writes, then random
// phases over several capacities, with bursts and gaps on the request side.
// A shadow copy of the entry table predicts gets the directed rows leave open;
// results are checked field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;
  import lkv_pkg::*;

  localparam int MAX_ENTRIES = 16;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int N_PHASES = 10;
  localparam int N_ROWS = 25;
  localparam int DRAIN_CYCLES = 4;

  typedef enum logic {
    ROW_REQ = 1'b0,
    ROW_CFG = 1'b1
  } row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    lkv_cmd_t                  command;
    logic [KEY_W-1:0]          key;
    logic signed [VALUE_W-1:0] value;
    bit                        typed;
    lkv_out_t                  exp;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  lkv_in_t          request = '0;
  logic             done;
  lkv_out_t         result;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  bit       row_typed = 1'b0;
  lkv_out_t row_exp = '0;

  bit                        shadow_valid [MAX_ENTRIES];
  logic [KEY_W-1:0]          shadow_key   [MAX_ENTRIES];
  logic signed [VALUE_W-1:0] shadow_value [MAX_ENTRIES];
  int                        shadow_age   [MAX_ENTRIES];
  int                        shadow_count = 0;
  logic [CAP_W-1:0]          shadow_capacity = CAP_RESET;

  lkv_out_t pending_reads [$];
  int       mismatches = 0;

  dir_row_t directed [N_ROWS] = '{
    '{ROW_REQ, CMD_GET, 31'h00000000, 32'sh00000000, 1'b1, '{1'b0, MISS_VALUE}},
    '{ROW_REQ, CMD_GET, 31'h7FFFFFFF, 32'sh00000000, 1'b1, '{1'b0, MISS_VALUE}},
    '{ROW_REQ, CMD_PUT, 31'h00000000, 32'sh80000000, 1'b0, '{1'b0, 32'sh0}},
    '{ROW_REQ, CMD_GET, 31'h00000000, 32'sh00000000, 1'b1, '{1'b1, 32'sh80000000}},
    '{ROW_REQ, CMD_PUT, 31'h7FFFFFFF, 32'sh7FFFFFFF, 1'b0, '{1'b0, 32'sh0}},
    '{ROW_REQ, CMD_GET, 31'h7FFFFFFF, 32'sh7FFFFFFF, 1'b1, '{1'b1, 32'sh7FFFFFFF}},
    '{ROW_REQ, CMD_PUT, 31'h00000000, 32'shFFFFFFFF, 1'b0, '{1'b0, 32'sh0}},
    '{ROW_REQ, CMD_GET, 31'h00000000, 32'sh00000000, 1'b1, '{1'b1, 32'shFFFFFFFF}},
    '{ROW_REQ, CMD_PUT, 31'h2AAAAAAA, 32'sh55555555, 1'b0, '{1'b0, 32'sh0}},
    '{ROW_REQ, CMD_GET, 31'h55555555, 32'shAAAAAAAA, 1'b1, '{1'b0, MISS_VALUE}},
    '{ROW_REQ, CMD_GET, 31'h2AAAAAAA, 32'sh00000000, 1'b1, '{1'b1, 32'sh55555555}},
    '{ROW_CFG, CMD_GET, 31'h00000000, 32'sh00000001, 1'b0, '{1'b0, 32'sh0}},
    '{ROW_REQ, CMD_PUT, 31'h00000123, 32'sh00000007, 1'b0, '{1'b0, 32'sh0}},
    '{ROW_REQ, CMD_GET, 31'h7FFFFFFF, 32'sh00000000, 1'b0, '{1'b0, 32'sh0}},
    '{ROW_REQ, CMD_GET, 31'h00000123, 32'sh00000000, 1'b0, '{1'b0, 32'sh0}},
    '{ROW_CFG, CMD_GET, 31'h00000000, 32'sh00000000, 1'b0, '{1'b0, 32'sh0}},
    '{ROW_REQ, CMD_PUT, 31'h00000456, -32'sd5,       1'b0, '{1'b0, 32'sh0}},
    '{ROW_REQ, CMD_GET, 31'h00000000, 32'sh00000000, 1'b0, '{1'b0, 32'sh0}},
    '{ROW_REQ, CMD_GET, 31'h00000456, 32'sh00000000, 1'b0, '{1'b0, 32'sh0}},
    '{ROW_CFG, CMD_GET, 31'h00000000, 32'sh0000001F, 1'b0, '{1'b0, 32'sh0}},
    '{ROW_REQ, CMD_PUT, 31'h00000001, 32'sh00000001, 1'b0, '{1'b0, 32'sh0}},
    '{ROW_REQ, CMD_PUT, 31'h00000002, 32'sh00000002, 1'b0, '{1'b0, 32'sh0}},
    '{ROW_REQ, CMD_GET, 31'h00000001, 32'sh00000000, 1'b0, '{1'b0, 32'sh0}},
    '{ROW_REQ, CMD_GET, 31'h00000456, 32'sh00000000, 1'b0, '{1'b0, 32'sh0}},
    '{ROW_CFG, CMD_GET, 31'h00000000, 32'sh00000010, 1'b0, '{1'b0, 32'sh0}}
  };

  logic [CAP_W-1:0] phase_caps [N_PHASES] = '{
    5'd16, 5'd1, 5'd0, 5'd2, 5'd31, 5'd3, 5'd8, 5'd17, 5'd16, 5'd5
  };

  lru_key_value_cache #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i]   = '0;
      shadow_value[i] = '0;
      shadow_age[i]   = 0;
    end
  end

  function automatic void make_most_recent(input int idx);
    int old_age;
    old_age = shadow_age[idx];
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (shadow_valid[i] && i != idx && shadow_age[i] < old_age) begin
        shadow_age[i]++;
      end
    end
    shadow_age[idx] = 0;
  endfunction

  task automatic cache_access(input lkv_in_t req, output bit gives, output lkv_out_t res);
    int found;
    int victim;
    int limit;
    found = -1;
    gives = 1'b0;
    res = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (shadow_valid[i] && shadow_key[i] == req.key) begin
        found = i;
      end
    end
    if (req.command == CMD_GET) begin
      gives = 1'b1;
      if (found >= 0) begin
        make_most_recent(found);
        res.hit = 1'b1;
        res.read_value = shadow_value[found];
      end else begin
        res.hit = 1'b0;
        res.read_value = MISS_VALUE;
      end
    end else if (found >= 0) begin
      shadow_value[found] = req.value;
      make_most_recent(found);
    end else begin
      if (shadow_capacity == 0) begin
        limit = 1;
      end else if (shadow_capacity > MAX_ENTRIES) begin
        limit = MAX_ENTRIES;
      end else begin
        limit = shadow_capacity;
      end
      if (shadow_count >= limit) begin
        victim = 0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (shadow_valid[i] &&
              (!shadow_valid[victim] || shadow_age[i] > shadow_age[victim])) begin
            victim = i;
          end
        end
        shadow_key[victim] = req.key;
        shadow_value[victim] = req.value;
        make_most_recent(victim);
      end else begin
        victim = -1;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
          if (!shadow_valid[i]) begin
            victim = i;
          end
        end
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (shadow_valid[i]) begin
            shadow_age[i]++;
          end
        end
        shadow_valid[victim] = 1'b1;
        shadow_key[victim] = req.key;
        shadow_value[victim] = req.value;
        shadow_age[victim] = 0;
        shadow_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    lkv_out_t want;
    lkv_out_t predicted;
    bit       gives;
    if (!rst) begin
      if (done) begin
        if (pending_reads.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result: hit=%0b read_value=%0d", result.hit,
                     result.read_value);
          end
          mismatches++;
        end else begin
          want = pending_reads.pop_front();
          if (result.hit !== want.hit) begin
            if (mismatches < 10) begin
              $display("hit mismatch: expected %0b, got %0b", want.hit, result.hit);
            end
            mismatches++;
          end
          if (result.read_value !== want.read_value) begin
            if (mismatches < 10) begin
              $display("read_value mismatch: expected %0d, got %0d", want.read_value,
                       result.read_value);
            end
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        cache_access(request, gives, predicted);
        if (gives) begin
          pending_reads.push_back(row_typed ? row_exp : predicted);
        end
      end
      if (cfg_valid && cfg_ready) begin
        shadow_capacity = cfg_data;
      end
    end
  end

  task automatic issue(input lkv_in_t req, input bit typed, input lkv_out_t exp);
    start <= 1'b1;
    request <= req;
    row_typed <= typed;
    row_exp <= exp;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    lkv_in_t          req;
    logic [KEY_W-1:0] key_pool [24];
    int               pool_size;
    int               burst_left;
    int               gap;
    int               eff_cap;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[r]) begin
      if (directed[r].kind == ROW_CFG) begin
        write_capacity(directed[r].value[CAP_W-1:0]);
      end else begin
        req.command = directed[r].command;
        req.key = directed[r].key;
        req.value = directed[r].value;
        issue(req, directed[r].typed, directed[r].exp);
      end
    end

    burst_left = $urandom_range(1, 20);
    for (int p = 0; p < N_PHASES; p++) begin
      if (p == N_PHASES - 1) begin
        write_capacity(CAP_W'($urandom_range(0, 31)));
      end else begin
        write_capacity(phase_caps[p]);
      end
      eff_cap = (shadow_capacity == 0) ? 1 :
                (shadow_capacity > MAX_ENTRIES) ? MAX_ENTRIES : shadow_capacity;
      pool_size = eff_cap + $urandom_range(1, 8);
      for (int k = 0; k < pool_size; k++) begin
        key_pool[k] = KEY_W'($urandom);
      end
      if ($urandom_range(0, 1)) begin
        key_pool[0] = '0;
        key_pool[1] = 31'h7FFFFFFF;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        req.command = lkv_cmd_t'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) begin
          req.key = KEY_W'($urandom);
        end else begin
          req.key = key_pool[$urandom_range(0, pool_size - 1)];
        end
        case ($urandom_range(0, 15))
          0: req.value = 32'sh80000000;
          1: req.value = 32'sh7FFFFFFF;
          2: req.value = MISS_VALUE;
          3: req.value = '0;
          default: req.value = $urandom;
        endcase
        issue(req, 1'b0, '0);
        burst_left--;
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst_left = $urandom_range(1, 20);
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_reads.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
